// ===== hw/rtl/mexp_pkg.sv =====
// mexp_pkg: widths, controller states and the command/status bundles
// shared by the modular exponentiation controller, datapath and top level
// no dependencies
package mexp_pkg;

    localparam int VAL_W = 31;
    localparam int EXP_W = 64;
    localparam int CNT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_GO,
        S_PRE_WAIT,
        S_BIT,
        S_ACC_GO,
        S_ACC_WAIT,
        S_SHIFT,
        S_SQR_GO,
        S_SQR_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_PRE,
        MUL_ACC,
        MUL_SQR
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    start;
        t_mul_op op;
        logic    wr_sq;
        logic    wr_acc;
        logic    shift_exp;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_bit0;
        logic exp_rest_zero;
        logic out_full;
    } t_sts;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// modular_exponentiation: top level, base^exponent mod modulus
// needs mexp_pkg, mexp_ctrl, mexp_dp (which holds mexp_mulmod)
//
//   channel  handshake           payload
//   input    i_valid / o_ready   i_base[30:0], i_exponent[63:0], i_modulus[30:0]
//   output   o_valid / i_ready   o_power_mod[30:0]
//
// one item at a time: the multiplier first reduces the base, then per exponent
// bit up to msb the controller tests the bit, multiplies when the bit is set,
// shifts, and squares while higher bits remain; all products come from the
// bit-serial multiplier. a finished beat sits in the output register while the
// next item is taken; the block stalls only when that register is still full.
// synchronous active-low reset clears the controller, the multiplier's busy and done flags and the output valid.
module modular_exponentiation (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mexp_pkg::VAL_W-1:0] i_base,
    input  logic [mexp_pkg::EXP_W-1:0] i_exponent,
    input  logic [mexp_pkg::VAL_W-1:0] i_modulus,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mexp_pkg::VAL_W-1:0] o_power_mod
);

    mexp_pkg::t_cmd cmd;
    mexp_pkg::t_sts sts;

    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mexp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_modulus   (i_modulus),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_power_mod (o_power_mod)
    );

endmodule

// ===== hw/rtl/mexp_mulmod.sv =====
// mexp_mulmod: serial shift-add modular multiplier, one bit of b per cycle
// result (a * b) mod m for a <= m, any 31-bit b; uses mexp_pkg widths
module mexp_mulmod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mexp_pkg::VAL_W-1:0] i_a,
    input  logic [mexp_pkg::VAL_W-1:0] i_b,
    input  logic [mexp_pkg::VAL_W-1:0] i_m,
    output logic                       o_done,
    output logic [mexp_pkg::VAL_W-1:0] o_r
);

    logic                       r_busy;
    logic                       r_done;
    logic [mexp_pkg::CNT_W-1:0] r_cnt;
    logic [mexp_pkg::VAL_W-1:0] r_a;
    logic [mexp_pkg::VAL_W-1:0] r_b;
    logic [mexp_pkg::VAL_W-1:0] r_r;
    logic [mexp_pkg::VAL_W-1:0] n_r;

    logic [mexp_pkg::VAL_W:0] t_dbl;
    logic [mexp_pkg::VAL_W:0] t_red;
    logic [mexp_pkg::VAL_W:0] t_sum;
    logic [mexp_pkg::VAL_W:0] t_fin;
    logic [mexp_pkg::VAL_W:0] t_m;

    always_comb begin
        t_m   = {1'b0, i_m};
        t_dbl = {r_r, 1'b0};
        t_red = (t_dbl >= t_m) ? t_dbl - t_m : t_dbl;
        t_sum = t_red + (r_b[mexp_pkg::VAL_W-1] ? {1'b0, r_a} : '0);
        t_fin = (t_sum >= t_m) ? t_sum - t_m : t_sum;
        n_r   = t_fin[mexp_pkg::VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_r   <= '0;
            r_cnt <= mexp_pkg::CNT_W'(mexp_pkg::VAL_W - 1);
        end else if (r_busy) begin
            r_r   <= n_r;
            r_b   <= {r_b[mexp_pkg::VAL_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

endmodule

// ===== hw/rtl/mexp_dp.sv =====
// mexp_dp: operand, accumulator, exponent and result registers around the
// serial modular multiplier; needs mexp_pkg and mexp_mulmod
module mexp_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mexp_pkg::t_cmd             i_cmd,
    output mexp_pkg::t_sts             o_sts,
    input  logic [mexp_pkg::VAL_W-1:0] i_base,
    input  logic [mexp_pkg::EXP_W-1:0] i_exponent,
    input  logic [mexp_pkg::VAL_W-1:0] i_modulus,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [mexp_pkg::VAL_W-1:0] o_power_mod
);

    logic [mexp_pkg::VAL_W-1:0] r_base;
    logic [mexp_pkg::VAL_W-1:0] r_mod;
    logic [mexp_pkg::EXP_W-1:0] r_exp;
    logic [mexp_pkg::VAL_W-1:0] r_acc;
    logic [mexp_pkg::VAL_W-1:0] r_sq;
    logic [mexp_pkg::VAL_W-1:0] r_out;
    logic                       r_out_valid;

    logic [mexp_pkg::VAL_W-1:0] mul_a;
    logic [mexp_pkg::VAL_W-1:0] mul_b;
    logic [mexp_pkg::VAL_W-1:0] mul_r;
    logic                       mul_done;

    always_comb begin
        case (i_cmd.op)
            mexp_pkg::MUL_PRE: begin
                mul_a = mexp_pkg::VAL_W'(1);
                mul_b = r_base;
            end
            mexp_pkg::MUL_ACC: begin
                mul_a = r_sq;
                mul_b = r_acc;
            end
            default: begin
                mul_a = r_sq;
                mul_b = r_sq;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_mod),
        .o_done  (mul_done),
        .o_r     (mul_r)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base;
            r_mod  <= i_modulus;
            r_exp  <= i_exponent;
            r_acc  <= (i_modulus != mexp_pkg::VAL_W'(1)) ? mexp_pkg::VAL_W'(1) : '0;
        end else begin
            if (i_cmd.wr_acc) begin
                r_acc <= mul_r;
            end
            if (i_cmd.shift_exp) begin
                r_exp <= {1'b0, r_exp[mexp_pkg::EXP_W-1:1]};
            end
        end
        if (i_cmd.wr_sq) begin
            r_sq <= mul_r;
        end
        if (i_cmd.load_out) begin
            r_out <= (r_mod == '0) ? '0 : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.mul_done      = mul_done;
        o_sts.exp_zero      = (r_exp == '0);
        o_sts.exp_bit0      = r_exp[0];
        o_sts.exp_rest_zero = (r_exp[mexp_pkg::EXP_W-1:1] == '0);
        o_sts.out_full      = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_power_mod = r_out;

endmodule

// ===== hw/rtl/mexp_ctrl.sv =====
// mexp_ctrl: sequencer for right-to-left square-and-multiply
// needs mexp_pkg; drives mexp_dp through command and status bundles
module mexp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mexp_pkg::t_sts i_sts,
    output mexp_pkg::t_cmd o_cmd
);

    mexp_pkg::t_state r_state;
    mexp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mexp_pkg::S_IDLE: begin
                if (i_valid) n_state = mexp_pkg::S_PRE_GO;
            end
            mexp_pkg::S_PRE_GO:   n_state = mexp_pkg::S_PRE_WAIT;
            mexp_pkg::S_PRE_WAIT: begin
                if (i_sts.mul_done) n_state = mexp_pkg::S_BIT;
            end
            mexp_pkg::S_BIT: begin
                if (i_sts.exp_zero)      n_state = mexp_pkg::S_DONE;
                else if (i_sts.exp_bit0) n_state = mexp_pkg::S_ACC_GO;
                else                     n_state = mexp_pkg::S_SHIFT;
            end
            mexp_pkg::S_ACC_GO:   n_state = mexp_pkg::S_ACC_WAIT;
            mexp_pkg::S_ACC_WAIT: begin
                if (i_sts.mul_done) n_state = mexp_pkg::S_SHIFT;
            end
            mexp_pkg::S_SHIFT: begin
                if (i_sts.exp_rest_zero) n_state = mexp_pkg::S_DONE;
                else                     n_state = mexp_pkg::S_SQR_GO;
            end
            mexp_pkg::S_SQR_GO:   n_state = mexp_pkg::S_SQR_WAIT;
            mexp_pkg::S_SQR_WAIT: begin
                if (i_sts.mul_done) n_state = mexp_pkg::S_BIT;
            end
            mexp_pkg::S_DONE: begin
                if (!i_sts.out_full) n_state = mexp_pkg::S_IDLE;
            end
            default: n_state = mexp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_cmd.op = mexp_pkg::MUL_PRE;
        o_ready = 1'b0;
        unique case (r_state)
            mexp_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            mexp_pkg::S_PRE_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = mexp_pkg::MUL_PRE;
            end
            mexp_pkg::S_PRE_WAIT: begin
                o_cmd.wr_sq = i_sts.mul_done;
            end
            mexp_pkg::S_ACC_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = mexp_pkg::MUL_ACC;
            end
            mexp_pkg::S_ACC_WAIT: begin
                o_cmd.wr_acc = i_sts.mul_done;
            end
            mexp_pkg::S_SHIFT: begin
                o_cmd.shift_exp = 1'b1;
            end
            mexp_pkg::S_SQR_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = mexp_pkg::MUL_SQR;
            end
            mexp_pkg::S_SQR_WAIT: begin
                o_cmd.wr_sq = i_sts.mul_done;
            end
            mexp_pkg::S_DONE: begin
                o_cmd.load_out = !i_sts.out_full;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule
